@@ hdl/rsve_pkg.sv @@
// Package with the shared types, constants and tables of the RTC set-time checker.
`default_nettype none
package rsve_pkg;

  // Configuration register indexes.
  localparam logic CfgEpochYear = 1'b0;
  localparam logic CfgBcdMode   = 1'b1;

  localparam int unsigned CfgDataW = 12;

  localparam logic [11:0] EpochReset = 12'd1900;
  localparam logic        BcdReset   = 1'b1;

  localparam logic [11:0] YearBase   = 12'd1900;
  localparam logic [11:0] YearMin    = 12'd1970;
  localparam logic [3:0]  MonthCount = 4'd12;
  localparam logic [7:0]  HourLimit  = 8'd24;
  localparam logic [7:0]  MinLimit   = 8'd60;
  localparam logic [7:0]  BcdLimit   = 8'd169;
  localparam logic [7:0]  BcdWrap    = 8'd100;

  // Division by 25 as a multiply by a reciprocal, exact for 12-bit years.
  localparam logic [12:0] Div25Mul   = 13'd5243;
  localparam int unsigned Div25Shift = 17;
  localparam logic [11:0] Twenty5    = 12'd25;

  localparam logic [3:0] FebIndex = 4'd1;

  // Days per month, indexed by the zero-based month.
  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [10:0] years_since_1900;
    logic [3:0]  month_index;
    logic [7:0]  day_of_month;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic [7:0]  second_in;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] year_code;
    logic [7:0] month_code;
    logic [7:0] day_code;
    logic [7:0] hour_code;
    logic [7:0] minute_code;
    logic [7:0] second_code;
  } out_item_t;

  // After the front stage: raw checks done, divide-by-25 quotient ready.
  typedef struct packed {
    logic [11:0] year;
    logic [7:0]  quot25;
    logic [3:0]  mon_idx;
    logic [7:0]  day;
    logic [7:0]  hrs;
    logic [7:0]  mins;
    logic [7:0]  secs;
    logic [7:0]  offset;
    logic        base_ok;
  } front_t;

  // After the judge stage: final verdict and adjusted year offset.
  typedef struct packed {
    logic       ok;
    logic [7:0] offset;
    logic [3:0] mon_idx;
    logic [7:0] day;
    logic [7:0] hrs;
    logic [7:0] mins;
    logic [7:0] secs;
  } judge_t;

endpackage
`default_nettype wire

@@ hdl/rsve_in_if.sv @@
// Channel interface for the broken-down date and time going into the block.
`default_nettype none
interface rsve_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] years_since_1900;
  logic [3:0]  month_index;
  logic [7:0]  day_of_month;
  logic [7:0]  hour_in;
  logic [7:0]  minute_in;
  logic [7:0]  second_in;

  modport source (
    output valid, years_since_1900, month_index, day_of_month, hour_in, minute_in,
           second_in,
    input  ready
  );
  modport sink (
    input  valid, years_since_1900, month_index, day_of_month, hour_in, minute_in,
           second_in,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/rsve_out_if.sv @@
// Channel interface for the status and register codes leaving the block.
`default_nettype none
interface rsve_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] year_code;
  logic [7:0] month_code;
  logic [7:0] day_code;
  logic [7:0] hour_code;
  logic [7:0] minute_code;
  logic [7:0] second_code;

  modport source (
    output valid, status, year_code, month_code, day_code, hour_code, minute_code,
           second_code,
    input  ready
  );
  modport sink (
    input  valid, status, year_code, month_code, day_code, hour_code, minute_code,
           second_code,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/rsve_front.sv @@
// First pipeline stage: year, range checks, epoch offset and divide-by-25 quotient.
`default_nettype none
module rsve_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire rsve_pkg::in_item_t item_i,
  input  wire logic [11:0]       epoch_year_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output rsve_pkg::front_t       stage_o
);

  logic             valid_q;
  rsve_pkg::front_t stage_d, stage_q;
  logic [11:0]      year;
  logic [24:0]      prod;
  logic [12:0]      diff;
  logic             time_ok, date_ok, off_ok;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    year    = 12'(item_i.years_since_1900) + rsve_pkg::YearBase;
    prod    = 25'(year) * 25'(rsve_pkg::Div25Mul);
    diff    = {1'b0, year} - {1'b0, epoch_year_i};
    off_ok  = !diff[12] && (diff[11:8] == 4'd0);
    time_ok = (item_i.hour_in < rsve_pkg::HourLimit) &&
              (item_i.minute_in < rsve_pkg::MinLimit) &&
              (item_i.second_in < rsve_pkg::MinLimit);
    date_ok = (item_i.month_index < rsve_pkg::MonthCount) &&
              (item_i.day_of_month != 8'd0);

    stage_d.year    = year;
    stage_d.quot25  = prod[rsve_pkg::Div25Shift +: 8];
    stage_d.mon_idx = item_i.month_index;
    stage_d.day     = item_i.day_of_month;
    stage_d.hrs     = item_i.hour_in;
    stage_d.mins    = item_i.minute_in;
    stage_d.secs    = item_i.second_in;
    stage_d.offset  = diff[7:0];
    stage_d.base_ok = (year >= rsve_pkg::YearMin) && time_ok && date_ok && off_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

@@ hdl/rsve_judge.sv @@
// Second pipeline stage: leap year, day limit, final verdict and BCD year fold.
`default_nettype none
module rsve_judge (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rsve_pkg::front_t stage_i,
  input  wire logic             bcd_mode_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rsve_pkg::judge_t      stage_o
);

  logic             valid_q;
  rsve_pkg::judge_t stage_d, stage_q;
  logic             div25, leap;
  logic [4:0]       day_lim;
  logic             ok;
  logic [7:0]       offset;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
    div25 = (12'(stage_i.quot25) * rsve_pkg::Twenty5) == stage_i.year;
    leap  = ((stage_i.year[1:0] == 2'd0) && !div25) ||
            ((stage_i.year[3:0] == 4'd0) && div25);

    day_lim = 5'd0;
    if (stage_i.mon_idx < rsve_pkg::MonthCount) begin
      day_lim = rsve_pkg::MonthLen[stage_i.mon_idx] +
                5'((stage_i.mon_idx == rsve_pkg::FebIndex) && leap);
    end

    ok     = stage_i.base_ok && (stage_i.day <= 8'(day_lim));
    offset = stage_i.offset;
    if (ok && bcd_mode_i) begin
      if (offset > rsve_pkg::BcdLimit) begin
        ok = 1'b0;
      end else if (offset >= rsve_pkg::BcdWrap) begin
        offset = offset - rsve_pkg::BcdWrap;
      end
    end

    stage_d.ok      = ok;
    stage_d.offset  = offset;
    stage_d.mon_idx = stage_i.mon_idx;
    stage_d.day     = stage_i.day;
    stage_d.hrs     = stage_i.hrs;
    stage_d.mins    = stage_i.mins;
    stage_d.secs    = stage_i.secs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

@@ hdl/rsve_encode.sv @@
// Third pipeline stage: BCD or binary encoding into the output register.
`default_nettype none
module rsve_encode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rsve_pkg::judge_t stage_i,
  input  wire logic             bcd_mode_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rsve_pkg::out_item_t   item_o
);

  logic                valid_q;
  rsve_pkg::out_item_t item_d, item_q;
  logic [7:0]          mon;

  // Two-digit BCD; tens come from a multiply by 103/1024, exact below 100.
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    prod = 16'(v) * 16'd103;
    tens = prod[13:10];
    ones = v - 8'(tens) * 8'd10;
    return {tens, ones[3:0]};
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mon    = 8'(stage_i.mon_idx) + 8'd1;
    item_d = '0;
    if (!stage_i.ok) begin
      item_d.status = 1'b1;
    end else if (bcd_mode_i) begin
      item_d.year_code   = to_bcd(stage_i.offset);
      item_d.month_code  = to_bcd(mon);
      item_d.day_code    = to_bcd(stage_i.day);
      item_d.hour_code   = to_bcd(stage_i.hrs);
      item_d.minute_code = to_bcd(stage_i.mins);
      item_d.second_code = to_bcd(stage_i.secs);
    end else begin
      item_d.year_code   = stage_i.offset;
      item_d.month_code  = mon;
      item_d.day_code    = stage_i.day;
      item_d.hour_code   = stage_i.hrs;
      item_d.minute_code = stage_i.mins;
      item_d.second_code = stage_i.secs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

@@ hdl/rtc_set_time_validate_encode.sv @@
// Top level of the RTC set-time checker and register code encoder.
//
//   Channel   Direction  Handshake     Carries
//   item_i    in         valid/ready   year since 1900, month, day, hour, minute, second
//   result_o  out        valid/ready   status and six register codes
//   cfg_*     in         write enable  epoch year (index 0), BCD mode (index 1)
//
// Every input item yields exactly one result; one item can be taken every cycle
// when the output side is ready. Each item passes through the three register
// stages: front checks with the divide-by-25 multiply, the leap and day-limit
// verdict, then the encoder, whose register drives result_o.
// A stall on result_o holds each stage that is full; empty stages still fill,
// so up to three items sit in the pipeline before item_i.ready drops.
// Reset clears the stage valid bits and loads epoch 1900 and BCD mode.
`default_nettype none
module rtc_set_time_validate_encode (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rsve_in_if.sink                            item_i,
  rsve_out_if.source                         result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [rsve_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers. The user must write them only while the pipeline is
  // empty; the block does not enforce this, and the stages read them live.
  logic [11:0] epoch_year_q;
  logic        bcd_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_year_q <= rsve_pkg::EpochReset;
      bcd_mode_q   <= rsve_pkg::BcdReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsve_pkg::CfgEpochYear: epoch_year_q <= cfg_data_i[11:0];
        rsve_pkg::CfgBcdMode:   bcd_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Gather the input channel into one payload word.
  rsve_pkg::in_item_t in_item;

  assign in_item.years_since_1900 = item_i.years_since_1900;
  assign in_item.month_index      = item_i.month_index;
  assign in_item.day_of_month     = item_i.day_of_month;
  assign in_item.hour_in          = item_i.hour_in;
  assign in_item.minute_in        = item_i.minute_in;
  assign in_item.second_in        = item_i.second_in;

  logic                front_valid, front_ready;
  rsve_pkg::front_t    front_stage;
  logic                judge_valid, judge_ready;
  rsve_pkg::judge_t    judge_stage;
  rsve_pkg::out_item_t out_item;
  logic                out_valid;

  // Stage one: range checks, epoch offset and the year quotient by 25.
  rsve_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (item_i.valid),
    .ready_o      (item_i.ready),
    .item_i       (in_item),
    .epoch_year_i (epoch_year_q),
    .valid_o      (front_valid),
    .ready_i      (front_ready),
    .stage_o      (front_stage)
  );

  // Stage two: leap rule, month length and the BCD year fold.
  rsve_judge u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .ready_o    (front_ready),
    .stage_i    (front_stage),
    .bcd_mode_i (bcd_mode_q),
    .valid_o    (judge_valid),
    .ready_i    (judge_ready),
    .stage_o    (judge_stage)
  );

  // Stage three: code encoding; its register is the output register.
  rsve_encode u_encode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (judge_valid),
    .ready_o    (judge_ready),
    .stage_i    (judge_stage),
    .bcd_mode_i (bcd_mode_q),
    .valid_o    (out_valid),
    .ready_i    (result_o.ready),
    .item_o     (out_item)
  );

  assign result_o.valid       = out_valid;
  assign result_o.status      = out_item.status;
  assign result_o.year_code   = out_item.year_code;
  assign result_o.month_code  = out_item.month_code;
  assign result_o.day_code    = out_item.day_code;
  assign result_o.hour_code   = out_item.hour_code;
  assign result_o.minute_code = out_item.minute_code;
  assign result_o.second_code = out_item.second_code;

endmodule
`default_nettype wire

@@ hdl/rsve_checker.sv @@
// Port-level checker for the RTC set-time checker, bound to the top level.
`default_nettype none
module rsve_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       status_i,
  input wire logic [7:0] year_code_i,
  input wire logic [7:0] month_code_i,
  input wire logic [7:0] day_code_i,
  input wire logic [7:0] hour_code_i,
  input wire logic [7:0] minute_code_i,
  input wire logic [7:0] second_code_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(year_code_i) &&
      $stable(month_code_i) && $stable(day_code_i) && $stable(hour_code_i) &&
      $stable(minute_code_i) && $stable(second_code_i))
    else $error("result changed while stalled");

  // Rejected items carry all-zero codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> year_code_i == 8'd0 && month_code_i == 8'd0 &&
      day_code_i == 8'd0 && hour_code_i == 8'd0 && minute_code_i == 8'd0 &&
      second_code_i == 8'd0)
    else $error("rejected item with nonzero codes");

  // Accepted items always have a month and a day from one upward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_i |-> month_code_i != 8'd0 && day_code_i != 8'd0)
    else $error("accepted item with zero month or day");

  // The input side stalls only when a result is held back by the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind rtc_set_time_validate_encode rsve_checker u_rsve_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .status_i      (result_o.status),
  .year_code_i   (result_o.year_code),
  .month_code_i  (result_o.month_code),
  .day_code_i    (result_o.day_code),
  .hour_code_i   (result_o.hour_code),
  .minute_code_i (result_o.minute_code),
  .second_code_i (result_o.second_code)
);
`default_nettype wire
